// ----- design/md5_stream_hasher_top_assert.svh -----
// Assertion macros for the MD5 stream hasher
`ifndef MD5_STREAM_HASHER_TOP_ASSERT_SVH
`define MD5_STREAM_HASHER_TOP_ASSERT_SVH
// Implication check, disabled during reset
`define MD5_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication check, disabled during reset
`define MD5_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- design/md5_pkg.sv -----
// ----------------------------------------------------------------------------
// md5_pkg
// Types, constants and round tables shared by the MD5 stream hasher.
// ----------------------------------------------------------------------------
package md5_pkg;
  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hEFCDAB89;
  localparam logic [31:0] INIT_C = 32'h98BADCFE;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_MARK = 8'h80;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       no_byte;
    logic       last_item;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_high;
    logic [63:0] digest_low;
  } out_item_t;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    begin
      unique case (r)
        6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
        6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
        6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
        6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
        6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
        6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
        6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
        6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
        6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
        6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
        6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
        default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] r);
    logic [4:0] s;
    begin
      unique case ({r[5:4], r[1:0]})
        4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
        4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
        4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'hA: s = 5'd16; 4'hB: s = 5'd23;
        4'hC: s = 5'd6;  4'hD: s = 5'd10; 4'hE: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
    end
  endfunction

  function automatic logic [3:0] round_w(input logic [5:0] r);
    logic [3:0] w;
    begin
      unique case (r[5:4])
        2'd0: w = r[3:0];
        2'd1: w = 4'(5 * r[3:0] + 1);
        2'd2: w = 4'(3 * r[3:0] + 5);
        default: w = 4'(7 * r[3:0]);
      endcase
      return w;
    end
  endfunction

  function automatic logic [63:0] pack_le(input logic [31:0] w0, input logic [31:0] w1);
    return {w0[7:0], w0[15:8], w0[23:16], w0[31:24],
            w1[7:0], w1[15:8], w1[23:16], w1[31:24]};
  endfunction
endpackage

// ----- design/md5_if.sv -----
// ----------------------------------------------------------------------------
// md5_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface md5_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/md5_fifo.sv -----
// ----------------------------------------------------------------------------
// md5_fifo
// Two-entry queue between the byte front end and the compression back end.
// ----------------------------------------------------------------------------
module md5_fifo
  import md5_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  in_item_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output in_item_t rd_data
);
  in_item_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= ~wp_r;
      if (rd_valid && rd_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem_r[wp_r] <= wr_data;
  end
endmodule

// ----- design/md5_core.sv -----
// ----------------------------------------------------------------------------
// md5_core
// Packs bytes into the block buffer, pads, runs one MD5 round per cycle
// and delivers the digest through an output register.
// ----------------------------------------------------------------------------
`include "md5_stream_hasher_top_assert.svh"
module md5_core
  import md5_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_ready,
  input  in_item_t  q_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ROUND = 5'b00010,
    S_PAD   = 5'b00100,
    S_LEN   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t      st_r;
  logic [31:0] blk_r [16];
  logic [31:0] h_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [5:0]  rnd_r, fill_r;
  logic [63:0] bits_r;
  logic        fin_r;   // message ending: padding pending
  logic        two_r;   // length goes into a second block
  logic        lenblk_r;
  out_item_t   out_r;
  logic        ov_r;

  logic        take;
  logic [31:0] f, sum, rot;
  logic [3:0]  wi;
  logic [1:0]  lane;
  logic [5:0]  fill_nxt;

  assign q_ready   = (st_r == S_IDLE) && !fin_r;
  assign take      = q_valid && q_ready;
  assign out_valid = ov_r;
  assign out_data  = out_r;
  assign wi        = round_w(rnd_r);
  assign lane      = fill_r[1:0];
  assign fill_nxt  = fill_r + 6'd1;

  always_comb begin
    unique case (rnd_r[5:4])
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (b_r & d_r) | (c_r & ~d_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    sum = a_r + f + round_k(rnd_r) + blk_r[wi];
    rot = (sum << round_s(rnd_r)) | (sum >> (6'd32 - {1'b0, round_s(rnd_r)}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; fill_r <= '0; bits_r <= '0; fin_r <= 1'b0; two_r <= 1'b0;
      ov_r <= 1'b0; rnd_r <= '0;
      h_r[0] <= INIT_A; h_r[1] <= INIT_B; h_r[2] <= INIT_C; h_r[3] <= INIT_D;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (fin_r) begin
            st_r <= S_PAD;
          end else if (take) begin
            if (!q_data.no_byte) begin
              if (lane == 2'd0) blk_r[fill_r[5:2]] <= {24'h0, q_data.msg_byte};
              else blk_r[fill_r[5:2]][lane*8 +: 8] <= q_data.msg_byte;
              bits_r <= bits_r + 64'd8;
              fill_r <= fill_nxt;
            end
            fin_r <= q_data.last_item;
            if (!q_data.no_byte && fill_r == 6'd63) begin
              st_r <= S_ROUND; rnd_r <= '0;
              a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
            end
          end
        end
        S_PAD: begin
          // mark and zero fill; extra block when mark lands at 56 or later
          for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < 4; j++) begin
              if (6'(i*4+j) == fill_r) blk_r[i][j*8 +: 8] <= PAD_MARK;
              else if (6'(i*4+j) > fill_r) blk_r[i][j*8 +: 8] <= 8'h0;
            end
          end
          two_r <= (fill_r >= 6'd56);
          if (fill_r >= 6'd56) begin
            st_r <= S_ROUND; rnd_r <= '0;
            a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
          end else begin
            st_r <= S_LEN;
          end
        end
        S_LEN: begin
          if (two_r) begin
            for (int i = 0; i < 14; i++) blk_r[i] <= 32'h0;
          end
          blk_r[14] <= bits_r[31:0];
          blk_r[15] <= bits_r[63:32];
          two_r <= 1'b0; fin_r <= 1'b0;
          st_r <= S_ROUND; rnd_r <= '0;
          a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
        end
        S_ROUND: begin
          a_r <= d_r; d_r <= c_r; c_r <= b_r; b_r <= b_r + rot;
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) begin
            h_r[0] <= h_r[0] + d_r; h_r[1] <= h_r[1] + b_r + rot;
            h_r[2] <= h_r[2] + b_r; h_r[3] <= h_r[3] + c_r;
            if (lenblk_r) st_r <= S_EMIT;
            else if (two_r) st_r <= S_LEN;
            else if (fin_r) st_r <= S_PAD;
            else st_r <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (!ov_r) begin
            ov_r <= 1'b1;
            out_r.digest_high <= pack_le(h_r[0], h_r[1]);
            out_r.digest_low  <= pack_le(h_r[2], h_r[3]);
            h_r[0] <= INIT_A; h_r[1] <= INIT_B; h_r[2] <= INIT_C; h_r[3] <= INIT_D;
            fill_r <= '0; bits_r <= '0;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) lenblk_r <= 1'b0;
    else if (st_r == S_LEN) lenblk_r <= 1'b1;
    else if (st_r == S_EMIT) lenblk_r <= 1'b0;
  end

  `MD5_ASSERT_IMP(a_no_take_busy, st_r != S_IDLE, !q_ready)
  `MD5_ASSERT_NXT(a_emit_valid, st_r == S_EMIT && !ov_r, ov_r)
  `MD5_ASSERT_IMP(a_round_first, st_r == S_LEN, !lenblk_r)
endmodule

// ----- design/md5_stream_hasher_top.sv -----
// ----------------------------------------------------------------------------
// md5_stream_hasher_top
// MD5 digest over a byte stream, one byte per input transfer.
// ----------------------------------------------------------------------------
// Input channel in_*: msg_byte, no_byte, last_item. A transfer with
// last_item set closes the message; no_byte with last_item ends it without
// a further byte (empty message if nothing came before).
// Output channel out_*: digest_high (bytes 0..7) and digest_low (bytes
// 8..15), one transfer per message.
// Bytes enter a two-entry queue and are packed one per cycle while the core
// is idle and not closing a message. Every 64th byte starts the compression,
// one round per cycle, during which the queue keeps taking up to two bytes.
// Closing a message runs the padding and length steps plus one or two
// blocks, then loads the output register once the previous digest is taken.
// Reset (synchronous, rst_n low) restores the initial chaining words and
// clears the length and fill counters. If the receiver stalls, the digest
// is held in the output register and the next message is absorbed until
// its own digest is due.
module md5_stream_hasher_top
  import md5_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  md5_if.sink   in_ch,
  md5_if.source out_ch
);
  logic     q_valid, q_ready;
  in_item_t q_data;

  md5_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(in_ch.valid), .wr_ready(in_ch.ready), .wr_data(in_ch.data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  md5_core u_core (
    .clk, .rst_n,
    .q_valid, .q_ready, .q_data,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule
